// ----- hw/rtl/led_pattern_and_button_supervisor_core_macros.svh -----
// Assertion helpers for the supervisor RTL, used by lpbs_core.
// Each use expects clk and rst_n in scope.
`ifndef LED_PATTERN_AND_BUTTON_SUPERVISOR_CORE_MACROS_SVH
`define LED_PATTERN_AND_BUTTON_SUPERVISOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define LPBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define LPBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lpbs_pkg.sv -----
package lpbs_pkg;

    // LED count and the number of LEDs that reach the pin fields
    localparam int LED_COUNT = 4;
    localparam int PIN_W     = 4;
    localparam int PIN_COUNT = (LED_COUNT < PIN_W) ? LED_COUNT : PIN_W;

    // Field widths
    localparam int OP_W      = 2;
    localparam int BTN_W     = 7;
    localparam int IDX_W     = 2;
    localparam int COLOUR_W  = 2;
    localparam int PATTERN_W = 16;
    localparam int PHASE_W   = 4;
    localparam int TICK_W    = 10;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Colour and button bits
    localparam int POWER_BIT      = 6;
    localparam int COLOUR_RED_BIT = 0;
    localparam int COLOUR_GRN_BIT = 1;

    localparam logic [COLOUR_W-1:0]  COLOUR_YELLOW = 2'b11;
    localparam logic [PATTERN_W-1:0] ALWAYS_ON     = 16'hFFFF;

    // Register reset values
    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 10'd50;
    localparam logic [TIME_W-1:0] IDLE_LIMIT_RST  = 32'd300000;
    localparam logic [TIME_W-1:0] HOLD_LIMIT_RST  = 32'd3000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_SET_LED    = 2'd1,
        OP_READ       = 2'd2,
        OP_CLEAR_IDLE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_PERIOD = 2'd0,
        CFG_IDLE_LIMIT  = 2'd1,
        CFG_HOLD_LIMIT  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        op_t                  op;
        logic [BTN_W-1:0]     pressed_mask;
        logic [IDX_W-1:0]     led_index;
        logic [COLOUR_W-1:0]  led_colour;
        logic [PATTERN_W-1:0] blink_pattern;
        logic                 continuous_read;
    } in_item_t;

    typedef struct packed {
        logic [PIN_W-1:0] red_pins;
        logic [PIN_W-1:0] green_pins;
        logic             power_off;
        logic [BTN_W-1:0] button_report;
        logic [BTN_W-1:0] single_button;
    } out_item_t;

endpackage

// ----- hw/rtl/led_pattern_and_button_supervisor_core.sv -----
// LED pattern and button supervisor. One item (tick, set LED, read buttons or
// clear idle time) is taken per clock cycle while in_stall is low and yields
// exactly one result item: it is held in the input register, then the whole
// update runs in a single pass of logic into the result register. When the
// result register is held by out_stall, one more item is still taken into the
// input register before in_stall rises. Configuration writes (tick period,
// idle limit, power hold limit) take effect on the next cycle and belong to
// idle periods. The power-off flag is sticky until reset; pins change only on
// ticks. No start-up pass is needed after reset.
module led_pattern_and_button_supervisor_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lpbs_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lpbs_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [lpbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lpbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lpbs_pkg::*;

    logic      stage_valid;
    in_item_t  stage_item;
    logic      advance;
    logic      step;
    out_item_t result;

    // An item updates state when it moves into the result register
    assign step = stage_valid && advance;

    lpbs_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    lpbs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (stage_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    lpbs_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .result      (result),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

// ----- hw/rtl/lpbs_in_stage.sv -----
module lpbs_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lpbs_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              stage_valid,
    output lpbs_pkg::in_item_t stage_item
);
    import lpbs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // Stall only when the held item cannot move on this cycle
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ----- hw/rtl/lpbs_core.sv -----
`include "led_pattern_and_button_supervisor_core_macros.svh"

module lpbs_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  lpbs_pkg::in_item_t                   item,
    input  logic                                 cfg_we,
    input  logic [lpbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    output lpbs_pkg::out_item_t                  result
);
    import lpbs_pkg::*;

    // Configuration
    logic [TICK_W-1:0] tick_period_reg;
    logic [TIME_W-1:0] idle_limit_reg;
    logic [TIME_W-1:0] hold_limit_reg;

    // Supervisor state
    logic [BTN_W-1:0]     cur_buttons_reg,  cur_buttons_next;
    logic [BTN_W-1:0]     last_rep_reg,     last_rep_next;
    logic [TIME_W-1:0]    idle_time_reg,    idle_time_next;
    logic [TIME_W-1:0]    hold_time_reg,    hold_time_next;
    logic [PHASE_W-1:0]   phase_reg,        phase_next;
    logic                 shutdown_reg,     shutdown_next;
    logic [PIN_W-1:0]     red_reg,          red_next;
    logic [PIN_W-1:0]     green_reg,        green_next;
    logic [PATTERN_W-1:0] pattern_reg [LED_COUNT];
    logic [PATTERN_W-1:0] pattern_next [LED_COUNT];
    logic [COLOUR_W-1:0]  colour_reg [LED_COUNT];
    logic [COLOUR_W-1:0]  colour_next [LED_COUNT];

    // Saturating timer sums
    logic [TIME_W:0]    idle_sum;
    logic [TIME_W:0]    hold_sum;
    logic [TIME_W-1:0]  idle_sat;
    logic [TIME_W-1:0]  hold_sat;
    logic [BTN_W-1:0]   report;
    logic [BTN_W-1:0]   single;

    assign idle_sum = {1'b0, idle_time_reg} + (TIME_W+1)'(tick_period_reg);
    assign hold_sum = {1'b0, hold_time_reg} + (TIME_W+1)'(tick_period_reg);
    assign idle_sat = idle_sum[TIME_W] ? '1 : idle_sum[TIME_W-1:0];
    assign hold_sat = hold_sum[TIME_W] ? '1 : hold_sum[TIME_W-1:0];

    // Next state for one item
    always_comb
    begin
        cur_buttons_next = cur_buttons_reg;
        last_rep_next    = last_rep_reg;
        idle_time_next   = idle_time_reg;
        hold_time_next   = hold_time_reg;
        phase_next       = phase_reg;
        shutdown_next    = shutdown_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        pattern_next     = pattern_reg;
        colour_next      = colour_reg;
        report           = '0;

        unique case (item.op)
            OP_TICK:
            begin
                cur_buttons_next = item.pressed_mask;

                // Idle timer runs while nothing is pressed
                if (item.pressed_mask == '0)
                begin
                    idle_time_next = idle_sat;
                    if (idle_sat > idle_limit_reg)
                    begin
                        shutdown_next = 1'b1;
                    end
                end
                else
                begin
                    idle_time_next = '0;
                end

                // Power button hold; timeout forces every LED to steady yellow
                if (item.pressed_mask[POWER_BIT])
                begin
                    hold_time_next = hold_sat;
                    if (hold_sat > hold_limit_reg)
                    begin
                        for (int j = 0; j < LED_COUNT; j++)
                        begin
                            colour_next[j]  = COLOUR_YELLOW;
                            pattern_next[j] = ALWAYS_ON;
                        end
                        shutdown_next = 1'b1;
                    end
                end
                else
                begin
                    hold_time_next = '0;
                end

                phase_next = phase_reg + 1'b1;

                // Pins from the new phase
                red_next   = '0;
                green_next = '0;
                for (int i = 0; i < PIN_COUNT; i++)
                begin
                    if (pattern_next[i][phase_next])
                    begin
                        red_next[i]   = colour_next[i][COLOUR_RED_BIT];
                        green_next[i] = colour_next[i][COLOUR_GRN_BIT];
                    end
                end
            end
            OP_SET_LED:
            begin
                for (int j = 0; j < LED_COUNT; j++)
                begin
                    if (int'(item.led_index) == j)
                    begin
                        colour_next[j]  = item.led_colour;
                        pattern_next[j] = item.blink_pattern;
                    end
                end
            end
            OP_READ:
            begin
                if (item.continuous_read || (cur_buttons_reg != last_rep_reg))
                begin
                    last_rep_next = cur_buttons_reg;
                    report        = cur_buttons_reg;
                end
            end
            OP_CLEAR_IDLE:
            begin
                idle_time_next = '0;
            end
            default:
            begin
                idle_time_next = idle_time_reg;
            end
        endcase
    end

    // Lowest pressed bit of the report
    assign single = report & (~report + 1'b1);

    assign result.red_pins      = red_next;
    assign result.green_pins    = green_next;
    assign result.power_off     = shutdown_next;
    assign result.button_report = report;
    assign result.single_button = single;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RST;
            idle_limit_reg  <= IDLE_LIMIT_RST;
            hold_limit_reg  <= HOLD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TICK_PERIOD: tick_period_reg <= cfg_data[TICK_W-1:0];
                CFG_IDLE_LIMIT:  idle_limit_reg  <= cfg_data[TIME_W-1:0];
                CFG_HOLD_LIMIT:  hold_limit_reg  <= cfg_data[TIME_W-1:0];
                default:         tick_period_reg <= tick_period_reg;
            endcase
        end
    end

    // State update when an item passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_buttons_reg <= '0;
            last_rep_reg    <= '0;
            idle_time_reg   <= '0;
            hold_time_reg   <= '0;
            phase_reg       <= '0;
            shutdown_reg    <= 1'b0;
            red_reg         <= '0;
            green_reg       <= '0;
            for (int j = 0; j < LED_COUNT; j++)
            begin
                pattern_reg[j] <= '0;
                colour_reg[j]  <= '0;
            end
        end
        else if (step)
        begin
            cur_buttons_reg <= cur_buttons_next;
            last_rep_reg    <= last_rep_next;
            idle_time_reg   <= idle_time_next;
            hold_time_reg   <= hold_time_next;
            phase_reg       <= phase_next;
            shutdown_reg    <= shutdown_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            pattern_reg     <= pattern_next;
            colour_reg      <= colour_next;
        end
    end

    // Checks
    `LPBS_ASSERT_NEXT(a_shutdown_sticky, shutdown_reg, shutdown_reg, "power-off flag dropped")
    `LPBS_ASSERT_NEXT(a_idle_cleared, step && (item.op == OP_CLEAR_IDLE), idle_time_reg == '0, "idle time not cleared")
    `LPBS_ASSERT_NEXT(a_hold_cleared, step && (item.op == OP_TICK) && !item.pressed_mask[POWER_BIT], hold_time_reg == '0, "hold time not cleared on release")
    `LPBS_ASSERT_SAME(a_single_onehot, step, $onehot0(result.single_button) && ((result.single_button & ~result.button_report) == '0), "single button not a bit of the report")

endmodule

// ----- hw/rtl/lpbs_out_stage.sv -----
module lpbs_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stage_valid,
    input  lpbs_pkg::out_item_t result,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_stall,
    output lpbs_pkg::out_item_t out_item
);
    import lpbs_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Result register can take a new item when empty or being drained
    assign advance = !valid_reg || !out_stall;

    always_comb
    begin
        if (advance)
        begin
            valid_next = stage_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            item_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- verif/led_pattern_and_button_supervisor_core_tb.sv -----
`timescale 1ns / 1ps

module led_pattern_and_button_supervisor_core_tb;
    import lpbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_PRINTED    = 50;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    led_pattern_and_button_supervisor_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the supervisor: registers and state
    logic [TICK_W-1:0]    tick_ms;
    logic [TIME_W-1:0]    idle_lim;
    logic [TIME_W-1:0]    hold_lim;
    logic [TIME_W-1:0]    idle_ms;
    logic [TIME_W-1:0]    hold_ms;
    logic [BTN_W-1:0]     btn_now;
    logic [BTN_W-1:0]     last_shown;
    logic [PHASE_W-1:0]   blink_phase;
    logic                 off_flag;
    logic [PATTERN_W-1:0] led_pat [LED_COUNT];
    logic [COLOUR_W-1:0]  led_col [LED_COUNT];
    logic [PIN_W-1:0]     red_q;
    logic [PIN_W-1:0]     green_q;

    in_item_t  pending_q[$];
    out_item_t expected_q[$];

    int errors     = 0;
    int n_checked  = 0;
    int n_tick     = 0;
    int n_set      = 0;
    int n_read     = 0;
    int n_clear    = 0;
    int n_yellow   = 0;
    int n_settings = 1;

    // Driver and stall generator state
    int   gap_left;
    int   send_calm;
    int   stall_left;
    int   stall_calm;
    logic drain_wait;
    int   quiet_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TICK_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + (TIME_W+1)'(b);
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    // Apply one item to the shadow state and return the result it should give
    function automatic out_item_t supervise(input in_item_t it);
        out_item_t        res;
        logic [BTN_W-1:0] shown;
        int               i;
        shown = '0;
        case (it.op)
            OP_TICK:
            begin
                n_tick++;
                btn_now = it.pressed_mask;
                if (btn_now == '0)
                begin
                    idle_ms = sat_add(idle_ms, tick_ms);
                    if (idle_ms > idle_lim)
                        off_flag = 1'b1;
                end
                else
                    idle_ms = '0;
                if (btn_now[POWER_BIT])
                begin
                    hold_ms = sat_add(hold_ms, tick_ms);
                    // power button timeout: all LEDs yellow, always lit
                    if (hold_ms > hold_lim)
                    begin
                        for (i = 0; i < LED_COUNT; i++)
                        begin
                            led_col[i] = COLOUR_YELLOW;
                            led_pat[i] = ALWAYS_ON;
                        end
                        off_flag = 1'b1;
                        n_yellow++;
                    end
                end
                else
                    hold_ms = '0;
                blink_phase = blink_phase + 1'b1;
                red_q   = '0;
                green_q = '0;
                for (i = 0; i < PIN_COUNT; i++)
                begin
                    red_q[i]   = led_pat[i][blink_phase] & led_col[i][COLOUR_RED_BIT];
                    green_q[i] = led_pat[i][blink_phase] & led_col[i][COLOUR_GRN_BIT];
                end
            end
            OP_SET_LED:
            begin
                n_set++;
                if (it.led_index < LED_COUNT)
                begin
                    led_col[it.led_index] = it.led_colour;
                    led_pat[it.led_index] = it.blink_pattern;
                end
            end
            OP_READ:
            begin
                n_read++;
                if (it.continuous_read || btn_now != last_shown)
                begin
                    last_shown = btn_now;
                    shown      = btn_now;
                end
            end
            default:
            begin
                n_clear++;
                idle_ms = '0;
            end
        endcase
        res.red_pins      = red_q;
        res.green_pins    = green_q;
        res.power_off     = off_flag;
        res.button_report = shown;
        res.single_button = shown & (~shown + 1'b1);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
    endtask

    // Pause length: mostly short, a few long, with calm stretches of none
    function automatic int random_pause(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t random_item(input op_t op);
        in_item_t it;
        it.op              = op;
        it.pressed_mask    = BTN_W'($urandom_range(0, 127));
        it.led_index       = IDX_W'($urandom_range(0, 3));
        it.led_colour      = COLOUR_W'($urandom_range(0, 3));
        it.blink_pattern   = PATTERN_W'($urandom_range(0, 65535));
        it.continuous_read = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic push_fields(input op_t op, input logic [BTN_W-1:0] mask,
                               input logic [IDX_W-1:0] idx,
                               input logic [COLOUR_W-1:0] col,
                               input logic [PATTERN_W-1:0] pat, input logic cont);
        in_item_t it;
        it.op              = op;
        it.pressed_mask    = mask;
        it.led_index       = idx;
        it.led_colour      = col;
        it.blink_pattern   = pat;
        it.continuous_read = cont;
        pending_q.push_back(it);
    endtask

    // Random traffic: power button holds, idle stretches and loose items
    task automatic queue_random(input int n);
        in_item_t it;
        int       base;
        int       r;
        base = pending_q.size();
        while (pending_q.size() - base < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    it = random_item(OP_TICK);
                    it.pressed_mask[POWER_BIT] = 1'b1;
                    pending_q.push_back(it);
                    if ($urandom_range(0, 3) == 0)
                        pending_q.push_back(random_item(op_t'($urandom_range(1, 3))));
                end
            end
            else if (r < 50)
            begin
                repeat ($urandom_range(1, 30))
                begin
                    it = random_item(OP_TICK);
                    it.pressed_mask = '0;
                    pending_q.push_back(it);
                    if ($urandom_range(0, 7) == 0)
                        pending_q.push_back(random_item(OP_READ));
                end
            end
            else if (r < 65)
                pending_q.push_back(random_item(OP_SET_LED));
            else if (r < 85)
                pending_q.push_back(random_item(OP_READ));
            else
                pending_q.push_back(random_item(op_t'($urandom_range(0, 3))));
        end
    endtask

    // Block until every item is sent and every result is back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TICK_PERIOD: tick_ms  = value[TICK_W-1:0];
            CFG_IDLE_LIMIT:  idle_lim = value;
            default:         hold_lim = value;
        endcase
    endtask

    task automatic run_phase(input logic [TICK_W-1:0] period,
                             input logic [TIME_W-1:0] idle_limit,
                             input logic [TIME_W-1:0] hold_limit, input int n);
        logic [CFG_DATA_W-1:0] tick_word;
        // upper bits of the tick write carry junk that must be dropped
        tick_word = $urandom;
        tick_word[TICK_W-1:0] = period;
        write_reg(CFG_TICK_PERIOD, tick_word);
        write_reg(CFG_IDLE_LIMIT, idle_limit);
        write_reg(CFG_HOLD_LIMIT, hold_limit);
        n_settings++;
        queue_random(n);
        wait_drained();
    endtask

    // Item driver: predicts on acceptance, holds while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            gap_left   = 0;
            send_calm  = 0;
            drain_wait = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(supervise(in_item));
            if (!in_valid || !in_stall)
            begin
                if (drain_wait && expected_q.size() == 0)
                    drain_wait = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (!drain_wait && pending_q.size() > 0)
                begin
                    in_item  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                    gap_left = random_pause(send_calm);
                    // now and then let the block empty out completely
                    if ($urandom_range(0, 199) == 0)
                        drain_wait = 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
            stall_calm = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = random_pause(stall_calm);
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no item outstanding", 32'(out_item), '0);
            else
            begin
                want = expected_q.pop_front();
                n_checked++;
                if (out_item.red_pins !== want.red_pins)
                    report_mismatch("red_pins", 32'(out_item.red_pins),
                                    32'(want.red_pins));
                if (out_item.green_pins !== want.green_pins)
                    report_mismatch("green_pins", 32'(out_item.green_pins),
                                    32'(want.green_pins));
                if (out_item.power_off !== want.power_off)
                    report_mismatch("power_off", 32'(out_item.power_off),
                                    32'(want.power_off));
                if (out_item.button_report !== want.button_report)
                    report_mismatch("button_report", 32'(out_item.button_report),
                                    32'(want.button_report));
                if (out_item.single_button !== want.single_button)
                    report_mismatch("single_button", 32'(out_item.single_button),
                                    32'(want.single_button));
            end
        end
    end

    // Watchdog on cycles where no item moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Sequence: reset, directed items at reset settings, then random phases
    initial
    begin
        tick_ms     = TICK_PERIOD_RST;
        idle_lim    = IDLE_LIMIT_RST;
        hold_lim    = HOLD_LIMIT_RST;
        idle_ms     = '0;
        hold_ms     = '0;
        btn_now     = '0;
        last_shown  = '0;
        blink_phase = '0;
        off_flag    = 1'b0;
        red_q       = '0;
        green_q     = '0;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            led_pat[i] = '0;
            led_col[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reads before any tick: nothing changed, then continuous
        push_fields(OP_READ, 7'h7F, 2'd3, 2'd3, 16'hFFFF, 1'b0);
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b1);
        // one LED of each colour
        push_fields(OP_SET_LED, 7'h00, 2'd0, 2'd1, 16'hAAAA, 1'b0);
        push_fields(OP_SET_LED, 7'h00, 2'd1, 2'd2, 16'h5555, 1'b0);
        push_fields(OP_SET_LED, 7'h00, 2'd2, 2'd3, 16'hFFFF, 1'b0);
        push_fields(OP_SET_LED, 7'h00, 2'd3, 2'd0, 16'hFFFF, 1'b0);
        push_fields(OP_TICK, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_TICK, 7'h7F, 2'd0, 2'd0, 16'h0000, 1'b0);
        // change-only read reports once, continuous read repeats
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b1);
        // set LED leaves the pins alone until the next tick
        push_fields(OP_SET_LED, 7'h7F, 2'd3, 2'd3, 16'h0000, 1'b1);
        push_fields(OP_TICK, 7'h40, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_TICK, 7'h20, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_TICK, 7'h01, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_CLEAR_IDLE, 7'h7F, 2'd3, 2'd3, 16'hFFFF, 1'b1);
        push_fields(OP_TICK, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_TICK, 7'h0C, 2'd0, 2'd0, 16'h0000, 1'b0);
        push_fields(OP_READ, 7'h00, 2'd0, 2'd0, 16'h0000, 1'b1);
        queue_random(300);
        wait_drained();

        // idle timeout first, while the power-off flag can still rise
        run_phase(10'd1023, 32'd20000, '1, 330);
        run_phase(10'd1000, '1, 32'd5000, 330);
        // zero period: timers never move
        run_phase(10'd0, 32'd0, 32'd0, 320);
        run_phase(10'd1, '1, 32'd3, 330);
        run_phase(TICK_PERIOD_RST, 32'd0, 32'd0, 320);

        $display("Covered %0d ticks, %0d LED writes, %0d reads, %0d idle clears",
                 n_tick, n_set, n_read, n_clear);
        $display("over %0d settings; %0d results compared; %0d power button timeouts; %s.",
                 n_settings, n_checked, n_yellow,
                 off_flag ? "power-off raised" : "power-off never raised");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lpbs_pkg.sv
hw/rtl/lpbs_in_stage.sv
hw/rtl/lpbs_core.sv
hw/rtl/lpbs_out_stage.sv
hw/rtl/led_pattern_and_button_supervisor_core.sv
verif/led_pattern_and_button_supervisor_core_tb.sv
